// ===== rtl/imu_pmwh_pkg.sv =====
// Shared types, constants and helper functions for the IMU peak-magnitude
// window hold block. No dependencies.

package imu_pmwh_pkg;

   localparam int AXIS_W  = 16;   // raw sensor axis width
   localparam int SQ_W    = 31;   // one axis squared, at most 2^30
   localparam int MAG_W   = 32;   // sum of three squares, at most 3 * 2^30
   localparam int CNT_W   = 4;    // attempts taken in the current window
   localparam int WIN_W   = 5;    // window length register
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(16);
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

   // register index, taken from the word address
   typedef enum logic {
      REG_PRESENT = 1'b0,
      REG_WINDOW  = 1'b1
   } csr_reg_type;

   typedef logic signed [AXIS_W-1:0] axis_type;

   typedef struct packed {
      axis_type acc_x;
      axis_type acc_y;
      axis_type acc_z;
      axis_type gyro_x;
      axis_type gyro_y;
      axis_type gyro_z;
   } sample_type;

   typedef struct packed {
      logic             present;
      logic [WIN_W-1:0] window;
   } cfg_type;

   // Square of one signed axis; |-32768| still fits 16 unsigned bits.
   function automatic logic [SQ_W-1:0] square_axis(input axis_type v);
      logic [AXIS_W-1:0]   a;
      logic [2*AXIS_W-1:0] p;
      a = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
      p = {{AXIS_W{1'b0}}, a} * {{AXIS_W{1'b0}}, a};
      return p[SQ_W-1:0];
   endfunction

   // Effective window length: zero acts as one, large values saturate.
   function automatic logic [WIN_W-1:0] window_len(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] n;
      if (w == '0) begin
         n = WIN_W'(1);
      end else if (w > WIN_MAX) begin
         n = WIN_MAX;
      end else begin
         n = w;
      end
      return n;
   endfunction

endpackage

// ===== rtl/imu_pmwh_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on imu_pmwh_pkg.

interface imu_pmwh_req_if;
   import imu_pmwh_pkg::*;

   logic     valid;
   logic     ready;
   logic     read_ok;
   axis_type acc_x;
   axis_type acc_y;
   axis_type acc_z;
   axis_type gyro_x;
   axis_type gyro_y;
   axis_type gyro_z;

   modport source (
      output valid, read_ok, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
      input  ready
   );
   modport sink (
      input  valid, read_ok, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
      output ready
   );
endinterface

interface imu_pmwh_rsp_if;
   import imu_pmwh_pkg::*;

   logic     valid;
   logic     ready;
   logic     imu_ok;
   axis_type out_acc_x;
   axis_type out_acc_y;
   axis_type out_acc_z;
   axis_type out_gyro_x;
   axis_type out_gyro_y;
   axis_type out_gyro_z;

   modport source (
      output valid, imu_ok, out_acc_x, out_acc_y, out_acc_z,
             out_gyro_x, out_gyro_y, out_gyro_z,
      input  ready
   );
   modport sink (
      input  valid, imu_ok, out_acc_x, out_acc_y, out_acc_z,
             out_gyro_x, out_gyro_y, out_gyro_z,
      output ready
   );
endinterface

// ===== rtl/imu_pmwh_csr.sv =====
// APB-style configuration registers: sensor_present and samples_per_window.
// Depends on imu_pmwh_pkg.

module imu_pmwh_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imu_pmwh_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [imu_pmwh_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [imu_pmwh_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready,
   output imu_pmwh_pkg::cfg_type             cfg
);
   import imu_pmwh_pkg::*;

   logic             present_ff;
   logic             present_in;
   logic [WIN_W-1:0] window_ff;
   logic [WIN_W-1:0] window_in;
   logic             wr_en;
   csr_reg_type      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[2]);

   // write decode
   always_comb begin
      present_in = present_ff;
      window_in  = window_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PRESENT: present_in = csr_pwdata[0];
            REG_WINDOW:  window_in  = csr_pwdata[WIN_W-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         window_ff  <= WIN_RESET;
      end else begin
         present_ff <= present_in;
         window_ff  <= window_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_PRESENT: csr_prdata = CSR_DW'(present_ff);
         REG_WINDOW:  csr_prdata = CSR_DW'(window_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg.present = present_ff;
   assign cfg.window  = window_ff;

endmodule

// ===== rtl/imu_pmwh_mag.sv =====
// Three parallel squarers for the accelerometer axes.
// Depends on imu_pmwh_pkg.

module imu_pmwh_mag (
   input  imu_pmwh_pkg::axis_type            acc_x,
   input  imu_pmwh_pkg::axis_type            acc_y,
   input  imu_pmwh_pkg::axis_type            acc_z,
   output logic [imu_pmwh_pkg::SQ_W-1:0]     sq_x,
   output logic [imu_pmwh_pkg::SQ_W-1:0]     sq_y,
   output logic [imu_pmwh_pkg::SQ_W-1:0]     sq_z
);
   import imu_pmwh_pkg::*;

   assign sq_x = square_axis(acc_x);
   assign sq_y = square_axis(acc_y);
   assign sq_z = square_axis(acc_z);

endmodule

// ===== rtl/imu_peak_magnitude_window_hold.sv =====
// Top level of the IMU peak-magnitude window hold block.
// Depends on imu_pmwh_pkg, imu_pmwh_if, imu_pmwh_csr and imu_pmwh_mag.

// Takes one read-attempt request per clock while ready is high. Each request
// is captured in an input register. From there three parallel 16x16 squarers,
// the magnitude sum and the compare against the kept peak update the window
// state as the request leaves it, and the last request of a window loads the
// window's result into the output register. Requests that close no window keep
// flowing while a result waits. Ready drops only when a window-closing request
// sits in the input register and the previous result has not been taken. There
// is no clearing pass after reset. The user must write configuration only with
// the pipeline empty; the block itself does not enforce this.

module imu_peak_magnitude_window_hold (
   input  logic                              clock,
   input  logic                              reset,
   imu_pmwh_req_if.sink                      req_ch,
   imu_pmwh_rsp_if.source                    rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imu_pmwh_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [imu_pmwh_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [imu_pmwh_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import imu_pmwh_pkg::*;

   cfg_type cfg;

   // input register
   logic            s1_v_ff;
   logic            s1_ok_ff;
   sample_type      s1_smp_ff;
   logic [SQ_W-1:0] sq_x, sq_y, sq_z;

   // window state
   sample_type       best_smp_ff, best_smp_in;
   logic [MAG_W-1:0] best_mag_ff, best_mag_in;
   logic             have_ff, have_in;
   logic [CNT_W-1:0] attempt_ff, attempt_in;
   sample_type       pub_ff, pub_in;

   // result register
   logic       rsp_v_ff, rsp_v_in;
   logic       rsp_ok_ff, rsp_ok_in;
   sample_type rsp_smp_ff, rsp_smp_in;

   logic             out_free;
   logic             s1_emit, s1_go, s1_take;
   logic [MAG_W-1:0] mag;
   logic [WIN_W-1:0] win_len, taken;
   logic             last, replace, have_nxt;
   sample_type       best_nxt, req_smp;

   imu_pmwh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imu_pmwh_mag u_mag (
      .acc_x (s1_smp_ff.acc_x),
      .acc_y (s1_smp_ff.acc_y),
      .acc_z (s1_smp_ff.acc_z),
      .sq_x  (sq_x),
      .sq_y  (sq_y),
      .sq_z  (sq_z)
   );

   assign req_smp.acc_x  = req_ch.acc_x;
   assign req_smp.acc_y  = req_ch.acc_y;
   assign req_smp.acc_z  = req_ch.acc_z;
   assign req_smp.gyro_x = req_ch.gyro_x;
   assign req_smp.gyro_y = req_ch.gyro_y;
   assign req_smp.gyro_z = req_ch.gyro_z;

   // window bookkeeping for the request in the input register
   assign mag      = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
   assign win_len  = window_len(cfg.window);
   assign taken    = WIN_W'(attempt_ff) + WIN_W'(1);
   assign last     = taken >= win_len;
   assign replace  = s1_ok_ff & (~have_ff | (mag > best_mag_ff));
   assign have_nxt = have_ff | s1_ok_ff;
   assign best_nxt = replace ? s1_smp_ff : best_smp_ff;

   // flow control: only a window-closing request waits for the output slot
   assign out_free = ~rsp_v_ff | rsp_ch.ready;
   assign s1_emit  = s1_v_ff & cfg.present & last;
   assign s1_go    = s1_v_ff & (~s1_emit | out_free);
   assign s1_take  = ~s1_v_ff | s1_go;
   assign req_ch.ready = s1_take;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_v_ff <= req_ch.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_ok_ff  <= req_ch.read_ok;
         s1_smp_ff <= req_smp;
      end
   end

   // window state next values
   always_comb begin
      best_smp_in = best_smp_ff;
      best_mag_in = best_mag_ff;
      have_in     = have_ff;
      attempt_in  = attempt_ff;
      pub_in      = pub_ff;
      if (s1_go && cfg.present) begin
         if (last) begin
            attempt_in  = '0;
            have_in     = 1'b0;
            best_mag_in = '0;
            if (have_nxt) begin
               pub_in = best_nxt;
            end
         end else begin
            attempt_in = taken[CNT_W-1:0];
            have_in    = have_nxt;
            if (replace) begin
               best_mag_in = mag;
               best_smp_in = s1_smp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_smp_ff <= '0;
         best_mag_ff <= '0;
         have_ff     <= 1'b0;
         attempt_ff  <= '0;
         pub_ff      <= '0;
      end else begin
         best_smp_ff <= best_smp_in;
         best_mag_ff <= best_mag_in;
         have_ff     <= have_in;
         attempt_ff  <= attempt_in;
         pub_ff      <= pub_in;
      end
   end

   // result register
   always_comb begin
      rsp_v_in   = rsp_v_ff & ~rsp_ch.ready;
      rsp_ok_in  = rsp_ok_ff;
      rsp_smp_in = rsp_smp_ff;
      if (s1_go && s1_emit) begin
         rsp_v_in   = 1'b1;
         rsp_ok_in  = have_nxt;
         rsp_smp_in = have_nxt ? best_nxt : pub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff  <= rsp_ok_in;
      rsp_smp_ff <= rsp_smp_in;
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.imu_ok     = rsp_ok_ff;
   assign rsp_ch.out_acc_x  = rsp_smp_ff.acc_x;
   assign rsp_ch.out_acc_y  = rsp_smp_ff.acc_y;
   assign rsp_ch.out_acc_z  = rsp_smp_ff.acc_z;
   assign rsp_ch.out_gyro_x = rsp_smp_ff.gyro_x;
   assign rsp_ch.out_gyro_y = rsp_smp_ff.gyro_y;
   assign rsp_ch.out_gyro_z = rsp_smp_ff.gyro_z;

   // a closed window leaves the tracking state cleared
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_emit) |=> (attempt_ff == '0) && !have_ff && (best_mag_ff == '0))
      else $error("window state not cleared after result");

   // no kept magnitude without a kept sample
   a_mag_needs_valid: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> (best_mag_ff == '0))
      else $error("magnitude held with no valid sample in window");

   // a pending result always shows the currently published sample
   a_rsp_matches_pub: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_smp_ff == pub_ff))
      else $error("result sample differs from published sample");

endmodule
